// ----- hdl/hsfc_pkg.sv -----
package hsfc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_e;

  // half to single, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [9:0]  mn;
    logic [31:0] r;
    sgn = h[15];
    e   = h[14:10];
    m   = h[9:0];
    lz  = 4'd0;
    // leading-zero count over the 10-bit mantissa
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    mn = 10'(({1'b0, m} << (lz + 4'd1)));
    if (e == 5'h1f) begin
      r = {sgn, 8'hff, (m != 10'd0), 22'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) r = {sgn, 31'd0};
      else r = {sgn, 8'(8'd112 - {4'd0, lz}), mn, 13'd0};
    end else begin
      r = {sgn, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // single to half, round to nearest even
  function automatic logic [31:0] single_to_half(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  e;
    logic [23:0] mb;
    logic [4:0]  sh;
    logic [4:0]  he;
    logic [24:0] mr;
    logic [11:0] mnt;
    logic [15:0] r;
    sgn = f[31];
    e   = f[30:23];
    mb  = {1'b0, f[22:0]};
    he  = 5'd0;
    sh  = 5'd0;
    mr  = 25'd0;
    mnt = 12'd0;
    if (e == 8'hff) begin
      r = {sgn, 5'h1f, (f[22:0] != 23'd0), 9'd0};
    end else if (e > 8'd142) begin
      r = {sgn, 5'h1f, 10'd0};
    end else if (e < 8'd102) begin
      r = {sgn, 15'd0};
    end else begin
      if (e < 8'd113) begin
        sh = 5'(8'd113 - e);
        mb = {1'b1, f[22:0]} >> sh;
        he = 5'd0;
      end else begin
        he = 5'(e - 8'd112);
      end
      mr = {1'b0, mb};
      if ({1'b0, mb[12:0]} > (14'h1000 - {13'd0, mb[13]})) mr = mr + 25'h2000;
      mnt = mr[24:13];
      r = {sgn, 15'(({10'd0, he} + {13'd0, mnt[11:10]}) << 10 | {5'd0, mnt[9:0]})};
    end
    return {16'd0, r};
  endfunction

endpackage

// ----- hdl/hsfc_core.sv -----
module hsfc_core (
  input  hsfc_pkg::op_e     op_i,
  input  logic [31:0]       operand_i,
  output logic [31:0]       result_o
);
  import hsfc_pkg::*;

  // direction select
  always_comb begin
    unique case (op_i)
      OP_H2S:  result_o = half_to_single(operand_i[15:0]);
      OP_S2H:  result_o = single_to_half(operand_i);
      default: result_o = '0;
    endcase
  end
endmodule

// ----- hdl/half_single_float_converter.sv -----
// half/single float converter
// input channel: valid_i/ready_o with op_i (0 = half to single,
// 1 = single to half) and operand_i. output channel: valid_o/ready_i
// with result_o. a beat is moved when valid and ready are both high.
// the input beat is captured in an input register; the conversion is
// combinational between it and the result register.
// the input beat passes through the input register and then the result
// register before valid_o rises.
// throughput: one beat per cycle while ready_i stays high, set by the two register stages.
// each stage advances when its downstream slot is free or being taken,
// so a stall on ready_i backs up through both stages and then drops
// ready_o; no beat is lost or repeated.
// reset clears both stage valid flags; no results are pending after it.
// half results sit in the low 16 bits with the upper half zero.
module half_single_float_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        op_i,
  input  logic [31:0] operand_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] result_o
);
  import hsfc_pkg::*;

  logic        in_vld_q;
  op_e         op_q;
  logic [31:0] operand_q;
  logic        out_vld_q;
  logic [31:0] result_q;
  logic [31:0] result_d;
  logic        out_adv;
  logic        in_adv;

  assign out_adv = !out_vld_q || ready_i;
  assign in_adv  = !in_vld_q || out_adv;
  assign ready_o = in_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && valid_i) begin
      op_q      <= op_e'(op_i);
      operand_q <= operand_i;
    end
  end

  hsfc_core u_core (
    .op_i      (op_q),
    .operand_i (operand_q),
    .result_o  (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = result_q;

  // a stalled result must not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(result_o)) else $error("result changed");

  // ready drops only when both stages are full
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> in_vld_q && out_vld_q && !ready_i) else $error("bad ready");

  // half results keep the upper half zero
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && op_q == OP_S2H |-> result_d[31:16] == 16'd0) else $error("upper bits set");

endmodule
